### hdl/ccpe_pkg.sv
// ----------------------------------------------------------------------------
// ccpe_pkg
// shared types, constants and functions of the crc / convolutional encoder
// ----------------------------------------------------------------------------
package ccpe_pkg;

   localparam int DATA_WIDTH      = 8;
   localparam int LEN_WIDTH       = 11;
   localparam int CRC_WIDTH       = 16;
   localparam int WORD_WIDTH      = 2 * DATA_WIDTH;
   localparam int MAX_RESULTS     = 4;
   localparam int RES_IDX_WIDTH   = 2;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CRC_WIDTH-1:0]  CRC_INIT         = 16'hFFFF;
   localparam logic [CRC_WIDTH-1:0]  CRC_POLY         = 16'hA001;
   localparam logic [DATA_WIDTH-1:0] FIRST_TAP_RESET  = 8'hAA;
   localparam logic [DATA_WIDTH-1:0] SECOND_TAP_RESET = 8'h99;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_TAP  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_TAP = 1'd1;

   // index of the final result of a transaction
   localparam logic [RES_IDX_WIDTH-1:0] LAST_IDX_SINGLE = 2'd0;
   localparam logic [RES_IDX_WIDTH-1:0] LAST_IDX_PAIR   = 2'd1;
   localparam logic [RES_IDX_WIDTH-1:0] LAST_IDX_QUAD   = 2'd3;

   // all results caused by one input transaction
   typedef struct packed {
      logic [MAX_RESULTS-1:0][DATA_WIDTH-1:0] bytes;
      logic [RES_IDX_WIDTH-1:0]               last_idx;
      logic                                   end_pkt;
      logic                                   err;
   } ccpe_result_type;

   // reflected crc-16, one byte
   function automatic logic [CRC_WIDTH-1:0] crc_byte(
      input logic [CRC_WIDTH-1:0]  crc,
      input logic [DATA_WIDTH-1:0] data
   );
      logic [CRC_WIDTH-1:0] c;
      c = crc ^ {{(CRC_WIDTH-DATA_WIDTH){1'b0}}, data};
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // rate one half encoding of a byte, msb first, given the prior shift register
   function automatic logic [WORD_WIDTH-1:0] conv_word(
      input logic [DATA_WIDTH-1:0] shift,
      input logic [DATA_WIDTH-1:0] data,
      input logic [DATA_WIDTH-1:0] tap_a,
      input logic [DATA_WIDTH-1:0] tap_b
   );
      logic [WORD_WIDTH-1:0] cat;
      logic [WORD_WIDTH-1:0] word;
      logic [DATA_WIDTH-1:0] window;
      cat  = {shift, data};
      word = '0;
      for (int k = 1; k <= DATA_WIDTH; k++) begin
         window                 = cat[WORD_WIDTH-1-k -: DATA_WIDTH];
         word[WORD_WIDTH+1-2*k] = ^(tap_a & window);
         word[WORD_WIDTH-2*k]   = ^(tap_b & window);
      end
      return word;
   endfunction

endpackage

### hdl/ccpe_if.sv
// ----------------------------------------------------------------------------
// ccpe_req_if / ccpe_rsp_if
// valid / ready channels of the packet encoder
// ----------------------------------------------------------------------------
interface ccpe_req_if;
   logic                                valid;
   logic                                ready;
   logic [ccpe_pkg::DATA_WIDTH-1:0]     data_byte;
   logic [ccpe_pkg::LEN_WIDTH-1:0]      packet_length;

   modport source (output valid, output data_byte, output packet_length, input ready);
   modport sink   (input valid, input data_byte, input packet_length, output ready);
endinterface

interface ccpe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ccpe_pkg::DATA_WIDTH-1:0]     out_byte;
   logic                                last_of_item;
   logic                                end_of_packet;
   logic                                length_error;

   modport source (output valid, output out_byte, output last_of_item,
                   output end_of_packet, output length_error, input ready);
   modport sink   (input valid, input out_byte, input last_of_item,
                   input end_of_packet, input length_error, output ready);
endinterface

### hdl/ccpe_core.sv
// ----------------------------------------------------------------------------
// ccpe_core
// input register, packet state, crc and convolutional encoding of one byte
// ----------------------------------------------------------------------------
module ccpe_core #(
   parameter int PREAMBLE_BYTES   = 5,
   parameter int MAX_PACKET_BYTES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [ccpe_pkg::DATA_WIDTH-1:0]    in_data,
   input  logic [ccpe_pkg::LEN_WIDTH-1:0]     in_length,
   input  logic [ccpe_pkg::DATA_WIDTH-1:0]    tap_a,
   input  logic [ccpe_pkg::DATA_WIDTH-1:0]    tap_b,
   output logic                               res_valid,
   input  logic                               res_free,
   output ccpe_pkg::ccpe_result_type          res
);
   import ccpe_pkg::*;

   localparam int MAX_CMP_WIDTH = 17;
   localparam logic [LEN_WIDTH:0]       MIN_LEN = (LEN_WIDTH+1)'(PREAMBLE_BYTES + 4);
   localparam logic [MAX_CMP_WIDTH-1:0] MAX_LEN = MAX_CMP_WIDTH'(MAX_PACKET_BYTES);
   localparam logic [LEN_WIDTH-1:0]     PRE_LEN = LEN_WIDTH'(PREAMBLE_BYTES);

   // input register
   logic                  hold_valid_ff, hold_valid_in;
   logic [DATA_WIDTH-1:0] hold_data_ff;
   logic [LEN_WIDTH-1:0]  hold_len_ff;

   // packet state
   logic [LEN_WIDTH-1:0]  pos_ff, pos_in;
   logic [LEN_WIDTH-1:0]  len_ff, len_in;
   logic [CRC_WIDTH-1:0]  crc_ff, crc_in;
   logic [DATA_WIDTH-1:0] shift_ff, shift_in;

   logic                  pop;
   logic                  first;
   logic                  bad_len;
   logic [LEN_WIDTH-1:0]  len_eff;
   logic                  in_preamble;
   logic                  slot_hi, slot_lo, feed, last_byte;
   logic [DATA_WIDTH-1:0] byte_eff;
   logic [WORD_WIDTH-1:0] word, flush;

   assign pop       = hold_valid_ff && res_free;
   assign in_ready  = !hold_valid_ff || res_free;
   assign res_valid = hold_valid_ff;

   assign hold_valid_in = (in_valid && in_ready) ? 1'b1 : (pop ? 1'b0 : hold_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hold_data_ff <= in_data;
         hold_len_ff  <= in_length;
      end
   end

   always_comb begin
      first       = (pos_ff == '0);
      bad_len     = first && (({1'b0, hold_len_ff} < MIN_LEN) ||
                    ({{(MAX_CMP_WIDTH-LEN_WIDTH){1'b0}}, hold_len_ff} > MAX_LEN));
      len_eff     = first ? hold_len_ff : len_ff;
      in_preamble = (pos_ff < PRE_LEN);
      slot_hi     = (pos_ff == len_eff - LEN_WIDTH'(4));
      slot_lo     = (pos_ff == len_eff - LEN_WIDTH'(3));
      // a length below five wraps the crc end mark, so every byte feeds it
      feed        = (len_eff < LEN_WIDTH'(5)) ||
                    (({1'b0, pos_ff} + (LEN_WIDTH+1)'(5)) <= {1'b0, len_eff});
      last_byte   = (({1'b0, pos_ff} + (LEN_WIDTH+1)'(1)) >= {1'b0, len_eff});

      if (slot_hi) begin
         byte_eff = crc_ff[CRC_WIDTH-1 -: DATA_WIDTH];
      end else if (slot_lo) begin
         byte_eff = crc_ff[DATA_WIDTH-1:0];
      end else begin
         byte_eff = hold_data_ff;
      end

      word  = conv_word(shift_ff, byte_eff, tap_a, tap_b);
      flush = conv_word(byte_eff, '0, tap_a, tap_b);

      pos_in   = pos_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      shift_in = shift_ff;
      res      = '0;

      if (bad_len) begin
         res.last_idx = LAST_IDX_SINGLE;
         res.err      = 1'b1;
      end else if (in_preamble) begin
         res.bytes[0] = hold_data_ff;
         res.last_idx = LAST_IDX_SINGLE;
         pos_in       = pos_ff + LEN_WIDTH'(1);
         len_in       = len_eff;
      end else begin
         res.bytes[0] = word[WORD_WIDTH-1 -: DATA_WIDTH];
         res.bytes[1] = word[DATA_WIDTH-1:0];
         if (last_byte) begin
            res.bytes[2] = flush[WORD_WIDTH-1 -: DATA_WIDTH];
            res.bytes[3] = flush[DATA_WIDTH-1:0];
            res.last_idx = LAST_IDX_QUAD;
            res.end_pkt  = 1'b1;
            pos_in       = '0;
            len_in       = '0;
            crc_in       = CRC_INIT;
            shift_in     = '0;
         end else begin
            res.last_idx = LAST_IDX_PAIR;
            pos_in       = pos_ff + LEN_WIDTH'(1);
            len_in       = len_eff;
            shift_in     = byte_eff;
            if (!slot_hi && !slot_lo && feed) begin
               crc_in = crc_byte(crc_ff, byte_eff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         crc_ff   <= CRC_INIT;
         shift_ff <= '0;
      end else if (pop) begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         shift_ff <= shift_in;
      end
   end

`ifndef SYNTH
   a_restart_after_packet : assert property (@(posedge clock) disable iff (reset)
      (pop && res.end_pkt) |=> (pos_ff == '0 && crc_ff == CRC_INIT && shift_ff == '0))
      else $error("packet state not restarted after last byte");

   a_error_keeps_start : assert property (@(posedge clock) disable iff (reset)
      (pop && res.err) |=> (pos_ff == '0))
      else $error("bad length moved the byte position");

   a_pos_within_len : assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> (pos_ff < len_ff))
      else $error("byte position beyond latched length");
`endif

endmodule

### hdl/ccpe_out_buf.sv
// ----------------------------------------------------------------------------
// ccpe_out_buf
// result register, hands out the results one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module ccpe_out_buf (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               res_valid,
   output logic                               res_free,
   input  ccpe_pkg::ccpe_result_type          res,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [ccpe_pkg::DATA_WIDTH-1:0]    out_byte,
   output logic                               out_last,
   output logic                               out_end,
   output logic                               out_err
);
   import ccpe_pkg::*;

   ccpe_result_type          result_ff;
   logic                     valid_ff, valid_in;
   logic [RES_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                     take, done, load;

   assign take     = valid_ff && out_ready;
   assign done     = take && (idx_ff == result_ff.last_idx);
   assign res_free = !valid_ff || done;
   assign load     = res_valid && res_free;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + RES_IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = result_ff.bytes[idx_ff];
   assign out_last  = (idx_ff == result_ff.last_idx);
   assign out_end   = result_ff.end_pkt && (idx_ff == result_ff.last_idx);
   assign out_err   = result_ff.err;

`ifndef SYNTH
   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff <= result_ff.last_idx))
      else $error("result index past final result");

   a_error_single : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && result_ff.err) |-> (result_ff.last_idx == LAST_IDX_SINGLE))
      else $error("error transaction with more than one result");

   a_end_on_quad : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && result_ff.end_pkt) |-> (result_ff.last_idx == LAST_IDX_QUAD))
      else $error("end of packet without flush bytes");
`endif

endmodule

### hdl/crc_conv_packet_encoder.sv
// ----------------------------------------------------------------------------
// crc_conv_packet_encoder
// crc-16 insertion and rate one half convolutional encoding of byte packets
// ----------------------------------------------------------------------------
// req_chan takes one packet byte per transaction with the packet length, which
// is latched at the first byte. rsp_chan gives the result bytes: one for each
// preamble byte, two for each later byte, four for the last byte of a packet
// (its two plus two flush bytes), one error result for a bad length.
// csr_* writes the two parity tap masks; write only while the block is idle.
// an accepted transaction is held in the input register and moves on to the
// result register once that is free; its results are offered from the result
// register.
// throughput: one result byte per cycle while rsp_chan.ready is high, set by
// the single result register.
// a new transaction is taken while the previous results are still draining.
// reset: synchronous, active high; empties both registers, starts a new packet
// and loads the tap masks with 0xaa and 0x99.
// rsp stall: results hold in the result register, the input register fills
// and req_chan.ready falls until the last result of the held transaction goes.
// ----------------------------------------------------------------------------
module crc_conv_packet_encoder #(
   parameter int PREAMBLE_BYTES   = 5,
   parameter int MAX_PACKET_BYTES = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   ccpe_req_if.sink                                req_chan,
   ccpe_rsp_if.source                              rsp_chan,
   input  logic                                    csr_write_enable,
   input  logic [ccpe_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ccpe_pkg::DATA_WIDTH-1:0]         csr_write_data
);
   import ccpe_pkg::*;

   // tap mask registers
   logic [DATA_WIDTH-1:0] tap_a_ff, tap_b_ff;

   // hand-over between encoder and result register
   logic            res_valid;
   logic            res_free;
   ccpe_result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_a_ff <= FIRST_TAP_RESET;
         tap_b_ff <= SECOND_TAP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_TAP:  tap_a_ff <= csr_write_data;
            CSR_SECOND_TAP: tap_b_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // input register, packet state, crc and encoding
   ccpe_core #(
      .PREAMBLE_BYTES   (PREAMBLE_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_chan.data_byte),
      .in_length (req_chan.packet_length),
      .tap_a     (tap_a_ff),
      .tap_b     (tap_b_ff),
      .res_valid (res_valid),
      .res_free  (res_free),
      .res       (res)
   );

   // result register, one byte per transaction on rsp_chan
   ccpe_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_free  (res_free),
      .res       (res),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .out_last  (rsp_chan.last_of_item),
      .out_end   (rsp_chan.end_of_packet),
      .out_err   (rsp_chan.length_error)
   );

endmodule

### tb/ccpe_checker.sv
// ----------------------------------------------------------------------------
// ccpe_checker
// watches both channels of the packet encoder, predicts its result bytes and
// compares every result transaction field by field
// ----------------------------------------------------------------------------
module ccpe_checker #(
   parameter int PREAMBLE_BYTES   = 5,
   parameter int MAX_PACKET_BYTES = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ccpe_req_if                                   req_mon,
   ccpe_rsp_if                                   rsp_mon,
   input  logic                                  csr_write_enable,
   input  logic [ccpe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ccpe_pkg::DATA_WIDTH-1:0]       csr_write_data,
   output int unsigned                           fail_count,
   output int unsigned                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ccpe_pkg::*;

   localparam int MIN_LENGTH = PREAMBLE_BYTES + 4;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] out_byte;
      logic                  last_of_item;
      logic                  end_of_packet;
      logic                  length_error;
   } encoded_byte_type;

   encoded_byte_type        expected_bytes[$];

   logic [LEN_WIDTH-1:0]    byte_pos;
   logic [LEN_WIDTH-1:0]    pkt_len;
   logic [CRC_WIDTH-1:0]    crc_acc;
   logic [DATA_WIDTH-1:0]   conv_shift;
   logic [DATA_WIDTH-1:0]   tap_first;
   logic [DATA_WIDTH-1:0]   tap_second;

   function automatic void queue_result(input logic [DATA_WIDTH-1:0] value,
                                        input logic last, input logic eop,
                                        input logic err);
      encoded_byte_type r;
      r.out_byte      = value;
      r.last_of_item  = last;
      r.end_of_packet = eop;
      r.length_error  = err;
      expected_bytes.push_back(r);
   endfunction

   function automatic void restart_packet();
      byte_pos   = '0;
      pkt_len    = '0;
      crc_acc    = CRC_INIT;
      conv_shift = '0;
   endfunction

   // msb first through the shift register, two parity bits per input bit
   function automatic void encode_byte(input logic [DATA_WIDTH-1:0] value,
                                       output logic [DATA_WIDTH-1:0] hi,
                                       output logic [DATA_WIDTH-1:0] lo);
      logic [WORD_WIDTH-1:0] word;
      word = '0;
      for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
         conv_shift = {conv_shift[DATA_WIDTH-2:0], value[i]};
         word = {word[WORD_WIDTH-3:0], ^(tap_first & conv_shift),
                 ^(tap_second & conv_shift)};
      end
      {hi, lo} = word;
   endfunction

   function automatic void predict_encoded_bytes(input logic [DATA_WIDTH-1:0] data_in,
                                                 input logic [LEN_WIDTH-1:0] len_in);
      logic [DATA_WIDTH-1:0] value;
      logic [DATA_WIDTH-1:0] hi;
      logic [DATA_WIDTH-1:0] lo;
      logic [CRC_WIDTH-1:0]  c;
      int unsigned           pos;
      value = data_in;
      if (byte_pos == '0) begin
         if (len_in < MIN_LENGTH || len_in > MAX_PACKET_BYTES) begin
            queue_result('0, 1'b1, 1'b0, 1'b1);
            return;
         end
         pkt_len = len_in;
      end
      pos = 32'(byte_pos);
      if (pos < PREAMBLE_BYTES) begin
         byte_pos = byte_pos + LEN_WIDTH'(1);
         queue_result(value, 1'b1, 1'b0, 1'b0);
         return;
      end
      if (pos == pkt_len - 4) begin
         value = crc_acc[CRC_WIDTH-1:DATA_WIDTH];
      end else if (pos == pkt_len - 3) begin
         value = crc_acc[DATA_WIDTH-1:0];
      end else if (pos <= pkt_len - 5) begin
         c = crc_acc ^ {{(CRC_WIDTH-DATA_WIDTH){1'b0}}, value};
         for (int i = 0; i < DATA_WIDTH; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         crc_acc = c;
      end
      encode_byte(value, hi, lo);
      queue_result(hi, 1'b0, 1'b0, 1'b0);
      if (pos + 1 >= pkt_len) begin
         queue_result(lo, 1'b0, 1'b0, 1'b0);
         encode_byte('0, hi, lo);
         queue_result(hi, 1'b0, 1'b0, 1'b0);
         queue_result(lo, 1'b1, 1'b1, 1'b0);
         restart_packet();
      end else begin
         byte_pos = byte_pos + LEN_WIDTH'(1);
         queue_result(lo, 1'b1, 1'b0, 1'b0);
      end
   endfunction

   function automatic void check_field(input string name,
                                       input logic [DATA_WIDTH-1:0] want,
                                       input logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      encoded_byte_type want;
      if (reset) begin
         tap_first  = FIRST_TAP_RESET;
         tap_second = SECOND_TAP_RESET;
         restart_packet();
         expected_bytes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result transaction: out_byte %0h", rsp_mon.out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_mon.out_byte);
               check_field("last_of_item", DATA_WIDTH'(want.last_of_item),
                           DATA_WIDTH'(rsp_mon.last_of_item));
               check_field("end_of_packet", DATA_WIDTH'(want.end_of_packet),
                           DATA_WIDTH'(rsp_mon.end_of_packet));
               check_field("length_error", DATA_WIDTH'(want.length_error),
                           DATA_WIDTH'(rsp_mon.length_error));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIRST_TAP:  tap_first  = csr_write_data;
               CSR_SECOND_TAP: tap_second = csr_write_data;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_encoded_bytes(req_mon.data_byte, req_mon.packet_length);
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the crc / convolutional packet encoder
// ----------------------------------------------------------------------------
// drives packets of random content with random idling on both channels,
// changes the tap masks between phases while the block is drained, and leaves
// the prediction and comparison to ccpe_checker
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccpe_pkg::*;

   localparam int PREAMBLE_BYTES   = 5;
   localparam int MAX_PACKET_BYTES = 1024;
   localparam int MIN_LENGTH       = PREAMBLE_BYTES + 4;
   localparam int RANDOM_ITEMS     = 210;
   localparam int PHASES           = 8;
   localparam int IDLE_PERCENT     = 9;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES     = 20;
   localparam int CYCLE_LIMIT      = 100000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [DATA_WIDTH-1:0]       csr_write_data;
   int unsigned                 fail_count;
   int unsigned                 pending_count;
   int unsigned                 cycle_count;
   int unsigned                 hold_left;
   bit                          calm_phase;
   bit                          long_hold_wanted;

   ccpe_req_if req_if();
   ccpe_rsp_if rsp_if();

   always #5 clock = ~clock;

   crc_conv_packet_encoder #(
      .PREAMBLE_BYTES   (PREAMBLE_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ccpe_checker #(
      .PREAMBLE_BYTES   (PREAMBLE_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // hard stop in case the block locks up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("crc_conv_packet_encoder verification failed");
         $finish;
      end
   end

   // result side: random back-pressure, none in the calm phase, and one long
   // hold-off on request so that the block fills and stalls its input
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
         end else if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            hold_left        = LONG_HOLD_CYCLES;
            rsp_if.ready    <= 1'b0;
         end else begin
            rsp_if.ready <= calm_phase || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // one input transaction; valid stays high afterwards until the next call
   // or an explicit drop, so a back-to-back byte needs only one assignment
   task automatic send_byte(input logic [DATA_WIDTH-1:0] value,
                            input logic [LEN_WIDTH-1:0] length);
      while (!calm_phase && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.data_byte     <= value;
      req_if.packet_length <= length;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
   endtask

   // a whole packet, or one byte for a bad length; later bytes carry a random
   // length that the block must ignore; a negative fill means random data
   task automatic send_packet(input logic [LEN_WIDTH-1:0] length, input int fill,
                              inout int unsigned sent);
      int unsigned count;
      count = (length < MIN_LENGTH || length > MAX_PACKET_BYTES) ? 1 : length;
      for (int unsigned i = 0; i < count; i++) begin
         send_byte(fill < 0 ? 8'($urandom_range(255)) : 8'(fill),
                   i == 0 ? length : 11'($urandom_range(MAX_PACKET_BYTES)));
         sent++;
      end
   endtask

   // stop offering and wait until every predicted byte has been seen
   task automatic wait_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_taps(input logic [DATA_WIDTH-1:0] first_taps,
                             input logic [DATA_WIDTH-1:0] second_taps);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIRST_TAP;
      csr_write_data   <= first_taps;
      @(posedge clock);
      csr_index        <= CSR_SECOND_TAP;
      csr_write_data   <= second_taps;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned            sent;
      logic [DATA_WIDTH-1:0]  first_taps;
      logic [DATA_WIDTH-1:0]  second_taps;
      req_if.valid         = 1'b0;
      req_if.data_byte     = '0;
      req_if.packet_length = '0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_FIRST_TAP;
      csr_write_data       = '0;
      calm_phase           = 1'b0;
      long_hold_wanted     = 1'b0;
      sent                 = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset tap masks: zero length, the longest bad length below
      // the minimum and one just above the maximum, then the shortest packet
      // (empty crc span) in ones and one longer in zeros
      send_packet(11'd0, 8'hFF, sent);
      send_packet(11'(MIN_LENGTH - 1), 8'h00, sent);
      send_packet(11'(MAX_PACKET_BYTES + 1), 8'h00, sent);
      send_packet(11'(MIN_LENGTH), 8'hFF, sent);
      send_packet(11'(MIN_LENGTH + 1), 8'h00, sent);

      // random phases, each starting from a drained block with new tap masks
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               first_taps  = 8'h00;
               second_taps = 8'h00;
            end
            1: begin
               first_taps  = 8'hFF;
               second_taps = 8'hFF;
            end
            2: begin
               first_taps  = 8'hFF;
               second_taps = 8'h00;
            end
            3: begin
               first_taps  = FIRST_TAP_RESET;
               second_taps = SECOND_TAP_RESET;
            end
            default: begin
               first_taps  = 8'($urandom);
               second_taps = 8'($urandom);
            end
         endcase
         write_taps(first_taps, second_taps);
         // no idling on either side for one whole phase
         calm_phase = (phase == 2);
         // long result hold-off while the sender keeps offering a full packet
         if (phase == 4) begin
            long_hold_wanted = 1'b1;
            send_packet(11'(MIN_LENGTH + 8), -1, sent);
         end
         // running budget over all phases, so an overshoot shortens the next
         while (sent < (RANDOM_ITEMS * (phase + 1)) / PHASES) begin
            if ($urandom_range(9) == 0) begin
               send_packet(11'($urandom_range(MIN_LENGTH - 1)), -1, sent);
            end else if ($urandom_range(7) == 0) begin
               send_packet(11'($urandom_range(64, MIN_LENGTH + 16)), -1, sent);
            end else begin
               send_packet(11'($urandom_range(MIN_LENGTH + 15, MIN_LENGTH)), -1,
                           sent);
            end
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("crc_conv_packet_encoder verification clean");
      end else begin
         $display("crc_conv_packet_encoder verification failed");
      end
      $finish;
   end

endmodule
